// ===== src/assert_macros.svh =====
// Assertion macros for the bubble collision time block.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define BCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define BCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== src/bct_pkg.sv =====
// Package of the bubble collision time block: constants, codes and types.
// Used by every other file but assert_macros.svh; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bct_pkg;
    localparam int MaxBubbles = 1024;
    localparam int IdxW       = $clog2(MaxBubbles);
    localparam int CntW       = $clog2(MaxBubbles + 1);

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_ANSWER  = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic CFG_BOX_SIZE = 1'b0;
    localparam logic CFG_MAX_TIME = 1'b1;

    // Quotient magnitude ceiling, 2^33.
    localparam logic [33:0] QuoMax = 34'h2_0000_0000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] nucleation_time;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [9:0]         self_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] collision_time;
        logic [1:0]         status;
        logic [10:0]        bubble_count;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] t;
    } t_bubble;

    typedef struct packed {
        logic               start;
        logic               ack;
    } t_eng_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [31:0] answer;
    } t_eng_stat;
endpackage
`default_nettype wire

// ===== src/bct_in_if.sv =====
// Input channel of the bubble collision time block: valid, ready and item.
// Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bct_in_if;
    logic              valid;
    logic              ready;
    bct_pkg::t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/bct_out_if.sv =====
// Result channel of the bubble collision time block: valid, ready and item.
// Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bct_out_if;
    logic               valid;
    logic               ready;
    bct_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/bct_store.sv =====
// Bubble store: one synchronous memory, one write and one read port,
// read data registered. Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bct_store (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [bct_pkg::IdxW-1:0]  i_waddr,
    input  bct_pkg::t_bubble         i_wdata,
    input  wire                      i_re,
    input  wire [bct_pkg::IdxW-1:0]  i_raddr,
    output bct_pkg::t_bubble         o_rdata
);
    bct_pkg::t_bubble mem [bct_pkg::MaxBubbles];
    bct_pkg::t_bubble r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/bct_div.sv =====
// Restoring divider, one quotient bit a cycle, quotient clamped to 2^33.
// Depends on bct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bct_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire [98:0]  i_num,
    input  wire [67:0]  i_den,
    output logic        o_done,
    output logic [33:0] o_quo
);
    logic [98:0]  r_rem;
    logic [101:0] r_dsh;
    logic [33:0]  r_q;
    logic         r_sat;
    logic [5:0]   r_step;
    logic         r_run;
    logic         r_done;
    logic         ge;

    assign ge = {3'b000, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_step == 6'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, 34'd0};
            r_q    <= '0;
            r_sat  <= 1'b0;
            r_step <= 6'd34;
        end else if (r_run) begin
            // top step only detects a quotient of 2^34 or more
            if (r_step == 6'd34) begin
                r_sat <= ge;
            end else begin
                r_q <= {r_q[32:0], ge};
                if (ge) begin
                    r_rem <= r_rem - r_dsh[98:0];
                end
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = (r_sat || r_q > bct_pkg::QuoMax) ? bct_pkg::QuoMax : r_q;
endmodule
`default_nettype wire

// ===== src/bct_engine.sv =====
// Query engine: walks the store, 27 images per bubble, shared multiplier,
// divider for the candidate time. Depends on bct_pkg and bct_div.
`timescale 1ns / 1ps
`default_nettype none
module bct_engine (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  bct_pkg::t_eng_req        i_req,
    input  bct_pkg::t_in_item        i_item,
    input  wire [bct_pkg::CntW-1:0]  i_count,
    input  wire [30:0]               i_box,
    input  wire signed [31:0]        i_max_time,
    output logic                     o_rd_en,
    output logic [bct_pkg::IdxW-1:0] o_rd_addr,
    input  bct_pkg::t_bubble         i_rd_data,
    output bct_pkg::t_eng_stat       o_stat
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_IMG  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_NEXT = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]               r_state;
    bct_pkg::t_in_item        r_q;
    logic [30:0]              r_box;
    logic [bct_pkg::IdxW-1:0] r_n;
    logic [bct_pkg::IdxW-1:0] r_last;
    logic signed [31:0]       r_best;
    logic signed [31:0]       r_bx, r_by, r_bz;
    logic signed [32:0]       r_s;
    logic [1:0]               r_oi, r_oj, r_ok;
    logic signed [33:0]       r_dx, r_dy, r_dz;
    logic [2:0]               r_ms;
    logic signed [67:0]       r_prod;
    logic signed [68:0]       r_d2;
    logic signed [66:0]       r_g;
    logic signed [67:0]       r_s2;
    logic                     r_neg;
    logic                     r_dstart;

    logic signed [33:0] lext, offx, offy, offz, dx, dy, dz;
    logic signed [33:0] ma, mb;
    logic signed [67:0] prod;
    logic signed [66:0] den;
    logic signed [68:0] num;
    logic [68:0]        mag;
    logic               skip;
    logic               ddone;
    logic [33:0]        quo;
    logic signed [35:0] cand;
    logic signed [31:0] cand_sat;

    always_comb begin
        lext = {3'b000, r_box};
        offx = (r_oi == 2'd0) ? -lext : ((r_oi == 2'd2) ? lext : '0);
        offy = (r_oj == 2'd0) ? -lext : ((r_oj == 2'd2) ? lext : '0);
        offz = (r_ok == 2'd0) ? -lext : ((r_ok == 2'd2) ? lext : '0);
        dx   = 34'(r_bx) + offx - 34'(r_q.pos_x);
        dy   = 34'(r_by) + offy - 34'(r_q.pos_y);
        dz   = 34'(r_bz) + offz - 34'(r_q.pos_z);
    end

    // operand select of the shared multiplier
    always_comb begin
        unique case (r_ms)
            3'd0: begin ma = r_dx; mb = r_dx; end
            3'd1: begin ma = r_dy; mb = r_dy; end
            3'd2: begin ma = r_dz; mb = r_dz; end
            3'd3: begin ma = 34'(r_q.dir_x); mb = r_dx; end
            3'd4: begin ma = 34'(r_q.dir_y); mb = r_dy; end
            3'd5: begin ma = 34'(r_q.dir_z); mb = r_dz; end
            default: begin ma = 34'(r_s); mb = 34'(r_s); end
        endcase
        prod = ma * mb;
    end

    always_comb begin
        den  = r_g + {{4{r_s[32]}}, r_s, 30'd0};
        num  = r_d2 - 69'(r_s2);
        mag  = num[68] ? 69'(-num) : 69'(num);
        skip = (r_d2 == '0) || den[66] || (den == '0);
    end

    bct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   ({mag[68:0], 30'd0}),
        .i_den   ({den[66:0], 1'b0}),
        .o_done  (ddone),
        .o_quo   (quo)
    );

    always_comb begin
        cand = r_neg ? (36'(r_q.nucleation_time) - $signed({2'b00, quo}))
                     : (36'(r_q.nucleation_time) + $signed({2'b00, quo}));
        if (cand > 36'sh0_7FFF_FFFF) begin
            cand_sat = 32'sh7FFF_FFFF;
        end else if (cand < -36'sh0_8000_0000) begin
            cand_sat = 32'sh8000_0000;
        end else begin
            cand_sat = cand[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_state <= (i_count == '0) ? S_DONE : S_RD;
                    end
                end
                S_RD:   r_state <= S_LOAD;
                S_LOAD: r_state <= S_IMG;
                S_IMG: begin
                    // skip the bubble's own unshifted image
                    if (r_oi == 2'd1 && r_oj == 2'd1 && r_ok == 2'd1
                        && r_n == r_q.self_index) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_ms == 3'd7) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (skip) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (ddone) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_oi == 2'd2 && r_oj == 2'd2 && r_ok == 2'd2) begin
                        r_state <= (r_n == r_last) ? S_DONE : S_RD;
                    end else begin
                        r_state <= S_IMG;
                    end
                end
                S_DONE: begin
                    if (i_req.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_q    <= i_item;
                r_box  <= i_box;
                r_best <= i_max_time;
                r_n    <= '0;
                r_last <= bct_pkg::IdxW'(i_count - bct_pkg::CntW'(1));
            end
            S_LOAD: begin
                r_bx <= i_rd_data.x;
                r_by <= i_rd_data.y;
                r_bz <= i_rd_data.z;
                r_s  <= 33'(r_q.nucleation_time) - 33'(i_rd_data.t);
                r_oi <= 2'd0;
                r_oj <= 2'd0;
                r_ok <= 2'd0;
            end
            S_IMG: begin
                r_dx <= dx;
                r_dy <= dy;
                r_dz <= dz;
                r_ms <= 3'd0;
                r_d2 <= '0;
                r_g  <= '0;
            end
            S_MUL: begin
                r_prod <= prod;
                r_ms   <= r_ms + 3'd1;
                if (r_ms >= 3'd1 && r_ms <= 3'd3) begin
                    r_d2 <= r_d2 + 69'(r_prod);
                end else if (r_ms >= 3'd4 && r_ms <= 3'd6) begin
                    r_g <= r_g + 67'(r_prod);
                end else if (r_ms == 3'd7) begin
                    r_s2 <= r_prod;
                end
            end
            S_CHK: r_neg <= num[68];
            S_DIV: begin
                if (ddone && cand_sat < r_best) begin
                    r_best <= cand_sat;
                end
            end
            S_NEXT: begin
                // advance the image digits, k fastest
                if (r_ok != 2'd2) begin
                    r_ok <= r_ok + 2'd1;
                end else begin
                    r_ok <= 2'd0;
                    if (r_oj != 2'd2) begin
                        r_oj <= r_oj + 2'd1;
                    end else begin
                        r_oj <= 2'd0;
                        r_oi <= r_oi + 2'd1;
                    end
                end
                if (r_oi == 2'd2 && r_oj == 2'd2 && r_ok == 2'd2) begin
                    r_n <= r_n + bct_pkg::IdxW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_rd_en       = (r_state == S_RD);
    assign o_rd_addr     = r_n;
    assign o_stat.busy   = (r_state != S_IDLE);
    assign o_stat.done   = (r_state == S_DONE);
    assign o_stat.answer = r_best;
endmodule
`default_nettype wire

// ===== src/bubble_collision_time.sv =====
// Bubble collision time: earliest collision of an expanding bubble with the
// stored bubbles of a periodic box. Load and clear go straight to the output
// register. A query walks the N stored bubbles, 27 images each, with shared
// multiplies and, unless skipped, a divide per image; one item is in flight
// at a time. Synchronous active-low reset clears control and count, loads
// box_size 1.0 and max_time.
`timescale 1ns / 1ps
`default_nettype none
module bubble_collision_time (
    input  wire              i_clk,
    input  wire              i_rst_n,
    bct_in_if.sink           i_in,
    bct_out_if.source        o_out,
    input  wire              i_cfg_we,
    input  wire              i_cfg_idx,
    input  wire [31:0]       i_cfg_data
);
`include "assert_macros.svh"

    logic [30:0]                r_box;
    logic signed [31:0]         r_max_time;
    logic [bct_pkg::CntW-1:0]   r_count;
    logic                       r_ov;
    bct_pkg::t_out_item         r_out;

    bct_pkg::t_eng_req          eng_req;
    bct_pkg::t_eng_stat         eng_stat;
    bct_pkg::t_bubble           wdata;
    bct_pkg::t_bubble           rdata;
    logic                       rd_en;
    logic [bct_pkg::IdxW-1:0]   rd_addr;
    logic                       out_free;
    logic                       accept;
    logic                       not_full;
    logic                       mem_we;

    // The output register is free when empty or being taken this cycle.
    assign out_free    = !r_ov || o_out.ready;
    assign i_in.ready  = !eng_stat.busy && out_free;
    assign accept      = i_in.valid && i_in.ready;
    assign not_full    = r_count < bct_pkg::CntW'(bct_pkg::MaxBubbles);
    assign mem_we      = accept && i_in.payload.opcode == bct_pkg::OP_LOAD && not_full;

    assign eng_req.start = accept && i_in.payload.opcode == bct_pkg::OP_QUERY;
    assign eng_req.ack   = eng_stat.done && out_free;

    assign wdata.x = i_in.payload.pos_x;
    assign wdata.y = i_in.payload.pos_y;
    assign wdata.z = i_in.payload.pos_z;
    assign wdata.t = i_in.payload.nucleation_time;

    bct_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[bct_pkg::IdxW-1:0]),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    bct_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (eng_req),
        .i_item     (i_in.payload),
        .i_count    (r_count),
        .i_box      (r_box),
        .i_max_time (r_max_time),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rdata),
        .o_stat     (eng_stat)
    );

    // Configuration writes: take the low 31 bits for the box edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box      <= 31'd65536;
            r_max_time <= 32'sh7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bct_pkg::CFG_BOX_SIZE: r_box      <= i_cfg_data[30:0];
                bct_pkg::CFG_MAX_TIME: r_max_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Store fill count and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (accept) begin
                priority case (i_in.payload.opcode)
                    bct_pkg::OP_LOAD: begin
                        if (not_full) begin
                            r_count <= r_count + bct_pkg::CntW'(1);
                        end
                        r_ov <= 1'b1;
                    end
                    bct_pkg::OP_CLEAR: begin
                        r_count <= '0;
                        r_ov    <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (eng_req.ack) begin
                r_ov <= 1'b1;
            end
        end
    end

    // Result payload: load and clear answer at once, a query when done.
    always_ff @(posedge i_clk) begin
        if (accept && i_in.payload.opcode == bct_pkg::OP_LOAD) begin
            r_out.collision_time <= '0;
            r_out.status         <= not_full ? bct_pkg::ST_LOADED : bct_pkg::ST_REFUSED;
            r_out.bubble_count   <= not_full ? r_count + bct_pkg::CntW'(1) : r_count;
        end else if (accept && i_in.payload.opcode == bct_pkg::OP_CLEAR) begin
            r_out.collision_time <= '0;
            r_out.status         <= bct_pkg::ST_CLEARED;
            r_out.bubble_count   <= '0;
        end else if (eng_req.ack) begin
            r_out.collision_time <= eng_stat.answer;
            r_out.status         <= bct_pkg::ST_ANSWER;
            r_out.bubble_count   <= r_count;
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

    `BCT_ASSERT(a_busy_blocks_in, eng_stat.busy |-> !i_in.ready, "input taken during a query")
    `BCT_ASSERT(a_count_bound, r_count <= bct_pkg::CntW'(bct_pkg::MaxBubbles), "count overflow")
    `BCT_ASSERT(a_full_holds, (accept && i_in.payload.opcode == bct_pkg::OP_LOAD && !not_full) |=> (r_count == bct_pkg::CntW'(bct_pkg::MaxBubbles)), "refused load changed count")
    `BCT_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !o_out.valid, "result valid after reset")
endmodule
`default_nettype wire

// ===== tb/bubble_collision_time_test.sv =====
// Self-checking test of the bubble collision time block: directed and random
// loads, queries and clears, with its own collision time predictor.
// Depends on bct_pkg, bct_in_if, bct_out_if and bubble_collision_time.
`timescale 1ns / 1ps
module bubble_collision_time_test;
    import bct_pkg::*;

    typedef logic signed [127:0] t_wide;

    // Shadow of the block: store, count and registers, plus expected results.
    class collision_scoreboard;
        t_bubble   store [MaxBubbles];
        int        held;
        bit [30:0] box;
        logic signed [31:0] no_hit_time;
        t_out_item pending_answers [$];

        function new();
            held        = 0;
            box         = 31'd65536;
            no_hit_time = 32'sh7FFF_FFFF;
        endfunction

        function logic signed [31:0] earliest_hit(t_in_item q);
            t_wide best, tq, s, s2, s30, side, dx, dy, dz, d2, g, den, num, cand;
            logic [127:0] mag, quo;
            bit neg;
            best = t_wide'(no_hit_time);
            tq   = t_wide'(q.nucleation_time);
            side = t_wide'({1'b0, box});
            for (int n = 0; n < held; n++) begin
                s   = tq - t_wide'(store[n].t);
                s2  = s * s;
                s30 = s <<< 30;
                for (int i = -1; i <= 1; i++)
                    for (int j = -1; j <= 1; j++)
                        for (int k = -1; k <= 1; k++) begin
                            if (i == 0 && j == 0 && k == 0 && n == int'(q.self_index))
                                continue;
                            dx = t_wide'(store[n].x) + t_wide'(i) * side - t_wide'(q.pos_x);
                            dy = t_wide'(store[n].y) + t_wide'(j) * side - t_wide'(q.pos_y);
                            dz = t_wide'(store[n].z) + t_wide'(k) * side - t_wide'(q.pos_z);
                            d2 = dx * dx + dy * dy + dz * dz;
                            // coincident image: undefined in float, drop it
                            if (d2 == 0)
                                continue;
                            g   = t_wide'(q.dir_x) * dx + t_wide'(q.dir_y) * dy
                                + t_wide'(q.dir_z) * dz;
                            den = g + s30;
                            if (den <= 0)
                                continue;
                            den = den + den;
                            num = d2 - s2;
                            neg = num < 0;
                            mag = neg ? -num : num;
                            mag = mag << 30;
                            quo = mag / $unsigned(den);
                            if (quo > 128'h2_0000_0000)
                                quo = 128'h2_0000_0000;
                            cand = neg ? tq - t_wide'(quo) : tq + t_wide'(quo);
                            if (cand > 128'sh7FFF_FFFF)
                                cand = 128'sh7FFF_FFFF;
                            if (cand < -128'sh8000_0000)
                                cand = -128'sh8000_0000;
                            if (cand < best)
                                best = cand;
                        end
            end
            return best[31:0];
        endfunction

        function void note_transfer(t_in_item it);
            t_out_item r;
            r = '0;
            case (it.opcode)
                OP_LOAD: begin
                    if (held < MaxBubbles) begin
                        store[held] = '{x: it.pos_x, y: it.pos_y, z: it.pos_z,
                                        t: it.nucleation_time};
                        held++;
                        r.status = ST_LOADED;
                    end else begin
                        r.status = ST_REFUSED;
                    end
                end
                OP_QUERY: begin
                    r.collision_time = earliest_hit(it);
                    r.status         = ST_ANSWER;
                end
                OP_CLEAR: begin
                    held     = 0;
                    r.status = ST_CLEARED;
                end
                default: return;  // unused opcode: no result
            endcase
            r.bubble_count = 11'(held);
            pending_answers = {pending_answers, r};
        endfunction

        // Returns an empty string when the transfer matches.
        function string check_transfer(t_out_item got);
            t_out_item want;
            if (pending_answers.size() == 0)
                return $sformatf("unexpected result %h", got);
            want = pending_answers.pop_front();
            if (got.collision_time !== want.collision_time || got.status !== want.status
                    || got.bubble_count !== want.bubble_count)
                return $sformatf("time %h/%h status %0d/%0d count %0d/%0d (got/want)",
                                 got.collision_time, want.collision_time, got.status,
                                 want.status, got.bubble_count, want.bubble_count);
            return "";
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    int          failures;
    bit          quiet;     // when set, neither side idles
    collision_scoreboard sb;

    bct_in_if  in_ch ();
    bct_out_if out_ch ();

    bubble_collision_time u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic report(string msg);
        failures++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    // Hold valid across back-to-back transfers; drop it only for a real gap.
    task automatic send(t_in_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_transfer(it);
    endtask

    task automatic park_sender();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pause the sender until every pending result has been drained.
    task automatic drain();
        park_sender();
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BOX_SIZE)
            sb.box = value[30:0];
        else
            sb.no_hit_time = value;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [1:0] op, int x, int y, int z, int t);
        t_in_item it;
        it = '0;
        it.opcode = op;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.nucleation_time = t;
        return it;
    endfunction

    function automatic int rand_dir();
        return int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    // Mostly positions inside a box or two, sometimes anywhere.
    function automatic int rand_pos();
        return ($urandom_range(0, 5) == 0) ? int'($urandom)
                                           : int'($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
    endfunction

    task automatic send_query(int x, int y, int z, int t, int hx, int hy, int hz,
                              int self_idx);
        t_in_item it;
        it = make_item(OP_QUERY, x, y, z, t);
        it.dir_x = hx;
        it.dir_y = hy;
        it.dir_z = hz;
        it.self_index = 10'(self_idx);
        send(it);
    endtask

    // Result side: stall a drawn number of cycles before each transfer.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            msg = sb.check_transfer(out_ch.payload);
            if (msg != "")
                report(msg);
        end
    end

    initial begin
        int n_items, n_load;
        sb           = new();
        failures     = 0;
        quiet        = 1'b0;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_BOX_SIZE;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.payload <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, query an empty store, then a few bubbles.
        send_query(0, 0, 0, 0, 32'sh4000_0000, 0, 0, 0);
        send(make_item(OP_LOAD, 0, 0, 0, 0));
        send(make_item(OP_LOAD, 32'sh8000, 0, 0, 32'sh1_0000));
        send(make_item(OP_LOAD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000));
        // centre on bubble 0: its own image skipped, coincident images dropped
        send_query(0, 0, 0, 0, 32'sh4000_0000, 0, 0, 0);
        send_query(0, 0, 0, 0, -32'sh4000_0000, 0, 0, 1);
        // self index past the count: nothing skipped on that account
        send_query(0, 0, 0, 0, 0, 32'sh4000_0000, 0, 1023);
        send_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   0, 0, -32'sh4000_0000, 2);
        send_query(32'sh1234, -32'sh4321, 32'sh777, 32'sh8000_0000,
                   32'sh2000_0000, 32'sh2000_0000, 32'sh2D41_3CCD, 512);
        send(make_item(2'd3, 5, 5, 5, 5));   // unused opcode: ignored
        send(make_item(OP_CLEAR, 0, 0, 0, 0));
        send_query(0, 0, 0, 0, 32'sh4000_0000, 0, 0, 0);

        // Extreme registers: smallest nonzero box with lowest no-hit time, then largest box.
        write_reg(CFG_BOX_SIZE, 32'd1);
        write_reg(CFG_MAX_TIME, 32'h8000_0000);
        send(make_item(OP_LOAD, 1, 0, 0, 0));
        send(make_item(OP_LOAD, 0, 0, 0, 32'sh7FFF_FFFF));
        send_query(0, 0, 0, 32'sh7FFF_FFFF, 32'sh4000_0000, 0, 0, 1);
        write_reg(CFG_BOX_SIZE, 32'h7FFF_FFFF);
        write_reg(CFG_MAX_TIME, 32'h7FFF_FFFF);
        send_query(0, 0, 0, 32'sh8000_0000, 32'sh4000_0000, 32'sh4000_0000,
                   32'sh4000_0000, 5);
        send(make_item(OP_CLEAR, 0, 0, 0, 0));

        // Fill the store with no idling, refuse one more load, then empty it.
        write_reg(CFG_BOX_SIZE, 32'd65536);
        quiet = 1'b1;
        for (int n = 0; n < MaxBubbles; n++)
            send(make_item(OP_LOAD, int'($urandom), int'($urandom), int'($urandom),
                           int'($urandom)));
        send(make_item(OP_LOAD, 1, 2, 3, 4));
        send(make_item(OP_CLEAR, 0, 0, 0, 0));
        drain();
        quiet = 1'b0;

        // Random phases: a short list of bubbles, then queries on it.
        n_items = 0;
        while (n_items < 100) begin
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_BOX_SIZE, ($urandom_range(0, 3) == 0)
                          ? {1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))}
                          : 32'($urandom_range(32'h8000, 32'h4_0000)));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_MAX_TIME, ($urandom_range(0, 1) == 0) ? $urandom
                          : 32'($urandom_range(0, 32'h8_0000)));
            quiet = ($urandom_range(0, 3) == 0);
            send(make_item(OP_CLEAR, 0, 0, 0, 0));
            n_load = $urandom_range(1, 6);
            for (int n = 0; n < n_load; n++)
                send(make_item(OP_LOAD, rand_pos(), rand_pos(), rand_pos(),
                               int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000));
            repeat ($urandom_range(2, 4)) begin
                send_query(rand_pos(), rand_pos(), rand_pos(),
                           ($urandom_range(0, 4) == 0) ? int'($urandom)
                               : int'($urandom_range(0, 32'h4_0000)) - 32'sh2_0000,
                           rand_dir(), rand_dir(), rand_dir(),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, n_load));
                n_items++;
            end
            if ($urandom_range(0, 4) == 0)
                send(make_item(2'd3, int'($urandom), 0, 0, 0));
            n_items += n_load + 1;
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (failures == 0 && sb.pending_answers.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Ceiling on run length, well above the slowest correct run.
    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
